// ----- src/tst_pkg.sv -----
// Shared constants, codes and record types of the task slot table.
package tst_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int MAX_RES = 16;
  localparam int LIM_W   = 5;

  typedef enum logic [2:0] {
    MODE_SPAWN      = 3'd0,
    MODE_START      = 3'd1,
    MODE_COMPLETE   = 3'd2,
    MODE_CANCEL     = 3'd3,
    MODE_CPU_REPORT = 3'd4,
    MODE_MEM_REPORT = 3'd5,
    MODE_LIST_OWNER = 3'd6,
    MODE_LIST_STATE = 3'd7
  } mode_e;

  localparam logic [2:0] PH_SPAWNED   = 3'd0;
  localparam logic [2:0] PH_RUNNING   = 3'd1;
  localparam logic [2:0] PH_COMPLETED = 3'd2;
  localparam logic [2:0] PH_CANCELLED = 3'd3;
  localparam logic [2:0] PH_FAILED    = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] owner;
    logic [63:0] ttl;
    logic [63:0] cycle_limit;
    logic [31:0] byte_limit;
    logic        sandbox;
    logic [31:0] result;
    logic [7:0]  out_len;
    logic [63:0] cycles_spent;
    logic [31:0] mem_used;
  } rec_t;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] result_value;
    logic [7:0]  out_len;
    logic [63:0] amount;
  } cmd_t;

  typedef struct packed {
    logic ok;
    rec_t rec;
  } upd_t;

endpackage

// ----- src/task_slot_table_with_budget_top.sv -----
// Top level of the task slot table: command sequencer around the record memory.
// A command transaction gives its single result through the S_EXEC state and the result registers.
// A listing scans the used slots in order and stops early at its limit.
// Throughput: one transaction at a time; busy is high until the final result is issued.
// The result strobe done_o lasts one cycle and cannot be held off by the receiver.
// Reset (rst_ni low, asynchronous) empties the table; the memory itself is not cleared.
module task_slot_table_with_budget_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [31:0] task_id_i,
  input  logic [15:0] owner_i,
  input  logic [63:0] ttl_i,
  input  logic [63:0] cycle_limit_i,
  input  logic [31:0] byte_limit_i,
  input  logic        sandboxed_i,
  input  logic signed [31:0] result_value_i,
  input  logic [7:0]  out_len_i,
  input  logic [63:0] amount_i,
  input  logic [2:0]  query_state_i,
  input  logic [4:0]  result_limit_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] out_task_id_o,
  output logic [2:0]  task_state_o,
  output logic [15:0] out_owner_o,
  output logic signed [31:0] out_result_code_o,
  output logic [63:0] out_cycles_spent_o,
  output logic [31:0] out_mem_used_o,
  output logic [7:0]  out_output_len_o,
  output logic        out_sandboxed_o,
  output logic        last_o
);
  import tst_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Slots fill in order and are never freed, so slot i holds id i+1 and the
  // fill count alone tells which slots are in use.
  logic [CNT_W-1:0]  used_q, used_d;

  // Latched transaction fields.
  mode_e             mode_q;
  logic [31:0]       id_q;
  logic [15:0]       owner_q;
  logic [63:0]       ttl_q;
  logic [63:0]       cpub_q;
  logic [31:0]       memb_q;
  logic              sbx_q;
  logic [31:0]       resv_q;
  logic [7:0]        olen_q;
  logic [63:0]       amount_q;
  logic [2:0]        qstate_q;
  logic [LIM_W-1:0]  limit_q;

  // Listing scan state: the slot whose record is in the read register, the
  // number of hits so far, and one held-back hit so that last can be set.
  logic [SLOT_W-1:0] scan_idx_q, scan_idx_d;
  logic [LIM_W-1:0]  hits_q, hits_d;
  logic              pend_vld_q, pend_vld_d;
  logic [SLOT_W-1:0] pend_idx_q, pend_idx_d;
  rec_t              pend_q, pend_d;

  // Memory port signals.
  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  rec_t              wdata, rdata;

  cmd_t              cmd;
  upd_t              upd;

  // Result registers.
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic [31:0]       tid_q, tid_d;
  logic [2:0]        phase_q, phase_d;
  logic [15:0]       rowner_q, rowner_d;
  logic [31:0]       rcode_q, rcode_d;
  logic [63:0]       rcpu_q, rcpu_d;
  logic [31:0]       rmem_q, rmem_d;
  logic [7:0]        rlen_q, rlen_d;
  logic              rsbx_q, rsbx_d;
  logic              last_q, last_d;

  logic              accept;
  logic              is_list_in;
  logic [LIM_W-1:0]  limit_in;
  logic              id_hit;
  logic [SLOT_W-1:0] id_slot;
  logic              scan_hit;
  logic              scan_end;
  logic [LIM_W-1:0]  hits_inc;
  logic [CNT_W-1:0]  used_m1;
  rec_t              spawn_rec;

  assign accept     = start && (state_q == S_IDLE);
  assign busy       = (state_q != S_IDLE);
  assign is_list_in = (mode_i == MODE_LIST_OWNER) || (mode_i == MODE_LIST_STATE);
  assign limit_in   = (result_limit_i > LIM_W'(MAX_RES)) ? LIM_W'(MAX_RES) : result_limit_i;

  // Id zero and ids beyond the filled slots match nothing.
  assign id_hit  = (id_q != '0) && (id_q <= 32'(used_q));
  assign id_slot = SLOT_W'(id_q - 32'd1);

  assign used_m1  = used_q - CNT_W'(1);
  assign scan_end = (scan_idx_q == used_m1[SLOT_W-1:0]);
  assign hits_inc = hits_q + LIM_W'(1);
  assign scan_hit = (mode_q == MODE_LIST_OWNER) ? (rdata.owner == owner_q)
                                                : (rdata.phase == qstate_q);

  // Read address: the addressed slot (slot zero for a listing) at acceptance, the next slot while scanning.
  always_comb begin
    raddr = '0;
    if (state_q == S_IDLE) begin
      raddr = is_list_in ? '0 : SLOT_W'(task_id_i - 32'd1);
    end else if (state_q == S_SCAN) begin
      raddr = scan_idx_q + SLOT_W'(1);
    end
  end

  assign cmd.mode         = mode_q;
  assign cmd.result_value = resv_q;
  assign cmd.out_len      = olen_q;
  assign cmd.amount       = amount_q;

  always_comb begin
    spawn_rec             = '0;
    spawn_rec.phase       = PH_SPAWNED;
    spawn_rec.owner       = owner_q;
    spawn_rec.ttl         = ttl_q;
    spawn_rec.cycle_limit = cpub_q;
    spawn_rec.byte_limit  = memb_q;
    spawn_rec.sandbox     = sbx_q;
  end

  tst_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tst_upd u_upd (
    .cmd_i (cmd),
    .rec_i (rdata),
    .upd_o (upd)
  );

  // Sequencer. A command writes back in the same cycle that it decides, and
  // the next transaction is accepted no earlier than the following edge, so a
  // read never overlaps a pending write of the same slot.
  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    scan_idx_d = scan_idx_q;
    hits_d     = hits_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    pend_d     = pend_q;
    we         = 1'b0;
    waddr      = id_slot;
    wdata      = upd.rec;
    done_d     = 1'b0;
    status_d   = ST_REJECT;
    tid_d      = '0;
    phase_d    = '0;
    rowner_d   = '0;
    rcode_d    = '0;
    rcpu_d     = '0;
    rmem_d     = '0;
    rlen_d     = '0;
    rsbx_d     = 1'b0;
    last_d     = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          scan_idx_d = '0;
          hits_d     = '0;
          pend_vld_d = 1'b0;
          if (is_list_in && used_q != '0 && limit_in != '0) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (mode_q == MODE_SPAWN) begin
          if (used_q < CNT_W'(SLOTS)) begin
            we       = 1'b1;
            waddr    = used_q[SLOT_W-1:0];
            wdata    = spawn_rec;
            used_d   = used_q + CNT_W'(1);
            status_d = ST_OK;
            tid_d    = 32'(used_q) + 32'd1;
            phase_d  = PH_SPAWNED;
          end
        end else if (mode_q == MODE_LIST_OWNER || mode_q == MODE_LIST_STATE) begin
          status_d = ST_EMPTY;
        end else if (id_hit && upd.ok) begin
          we       = 1'b1;
          status_d = ST_OK;
          tid_d    = id_q;
          phase_d  = upd.rec.phase;
        end
      end
      S_SCAN: begin
        scan_idx_d = scan_idx_q + SLOT_W'(1);
        if (scan_hit) begin
          // Release the held hit; it is not the last one.
          if (pend_vld_q) begin
            done_d   = 1'b1;
            status_d = ST_OK;
            tid_d    = 32'(pend_idx_q) + 32'd1;
            phase_d  = pend_q.phase;
            rowner_d = pend_q.owner;
            rcode_d  = pend_q.result;
            rcpu_d   = pend_q.cycles_spent;
            rmem_d   = pend_q.mem_used;
            rlen_d   = pend_q.out_len;
            rsbx_d   = pend_q.sandbox;
            last_d   = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_idx_d = scan_idx_q;
          pend_d     = rdata;
          hits_d     = hits_inc;
          if (hits_inc == limit_q || scan_end) begin
            state_d = S_FIN;
          end
        end else if (scan_end) begin
          if (pend_vld_q) begin
            state_d = S_FIN;
          end else begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            status_d = ST_EMPTY;
          end
        end
      end
      S_FIN: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        status_d = ST_OK;
        tid_d    = 32'(pend_idx_q) + 32'd1;
        phase_d  = pend_q.phase;
        rowner_d = pend_q.owner;
        rcode_d  = pend_q.result;
        rcpu_d   = pend_q.cycles_spent;
        rmem_d   = pend_q.mem_used;
        rlen_d   = pend_q.out_len;
        rsbx_d   = pend_q.sandbox;
        last_d   = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      done_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      hits_q     <= '0;
      scan_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      done_q     <= done_d;
      pend_vld_q <= pend_vld_d;
      hits_q     <= hits_d;
      scan_idx_q <= scan_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_e'(mode_i);
      id_q     <= task_id_i;
      owner_q  <= owner_i;
      ttl_q    <= ttl_i;
      cpub_q   <= cycle_limit_i;
      memb_q   <= byte_limit_i;
      sbx_q    <= sandboxed_i;
      resv_q   <= result_value_i;
      olen_q   <= out_len_i;
      amount_q <= amount_i;
      qstate_q <= query_state_i;
      limit_q  <= limit_in;
    end
    pend_idx_q <= pend_idx_d;
    pend_q     <= pend_d;
    status_q   <= status_d;
    tid_q      <= tid_d;
    phase_q    <= phase_d;
    rowner_q   <= rowner_d;
    rcode_q    <= rcode_d;
    rcpu_q     <= rcpu_d;
    rmem_q     <= rmem_d;
    rlen_q     <= rlen_d;
    rsbx_q     <= rsbx_d;
    last_q     <= last_d;
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign out_task_id_o      = tid_q;
  assign task_state_o       = phase_q;
  assign out_owner_o        = rowner_q;
  assign out_result_code_o  = rcode_q;
  assign out_cycles_spent_o = rcpu_q;
  assign out_mem_used_o     = rmem_q;
  assign out_output_len_o   = rlen_q;
  assign out_sandboxed_o    = rsbx_q;
  assign last_o             = last_q;

endmodule

// ----- src/tst_mem.sv -----
// Slot record memory: one write port, one registered read port.
module tst_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [tst_pkg::SLOT_W-1:0]  waddr_i,
  input  tst_pkg::rec_t               wdata_i,
  input  logic [tst_pkg::SLOT_W-1:0]  raddr_i,
  output tst_pkg::rec_t               rdata_o
);
  import tst_pkg::*;

  rec_t mem_q [SLOTS];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tst_upd.sv -----
// Read-modify-write unit: applies one lifecycle command to a slot record.
module tst_upd (
  input  tst_pkg::cmd_t cmd_i,
  input  tst_pkg::rec_t rec_i,
  output tst_pkg::upd_t upd_o
);
  import tst_pkg::*;

  logic [64:0] cpu_sum;
  logic [63:0] cpu_new;
  logic [32:0] mem_sum;

  assign cpu_sum = {1'b0, rec_i.cycles_spent} + {1'b0, cmd_i.amount};
  assign cpu_new = cpu_sum[64] ? '1 : cpu_sum[63:0];
  assign mem_sum = {1'b0, rec_i.mem_used} + {1'b0, cmd_i.amount[31:0]};

  always_comb begin
    upd_o.ok  = 1'b0;
    upd_o.rec = rec_i;
    unique case (cmd_i.mode)
      MODE_START: begin
        if (rec_i.phase == PH_SPAWNED) begin
          upd_o.rec.phase = PH_RUNNING;
          upd_o.ok        = 1'b1;
        end
      end
      MODE_COMPLETE: begin
        if (rec_i.phase == PH_RUNNING) begin
          upd_o.rec.phase   = PH_COMPLETED;
          upd_o.rec.result  = cmd_i.result_value;
          upd_o.rec.out_len = cmd_i.out_len;
          upd_o.ok          = 1'b1;
        end
      end
      MODE_CANCEL: begin
        if (rec_i.phase == PH_SPAWNED || rec_i.phase == PH_RUNNING) begin
          upd_o.rec.phase = PH_CANCELLED;
          upd_o.ok        = 1'b1;
        end
      end
      MODE_CPU_REPORT: begin
        if (rec_i.phase == PH_RUNNING) begin
          upd_o.rec.cycles_spent = cpu_new;
          // A nonzero budget that is now exceeded fails the task.
          if (rec_i.cycle_limit != '0 && cpu_new > rec_i.cycle_limit) begin
            upd_o.rec.phase  = PH_FAILED;
            upd_o.rec.result = '1;
          end
          upd_o.ok = 1'b1;
        end
      end
      MODE_MEM_REPORT: begin
        if (rec_i.phase == PH_RUNNING) begin
          upd_o.rec.mem_used = (|cmd_i.amount[63:32] || mem_sum[32]) ? '1 : mem_sum[31:0];
          upd_o.ok           = 1'b1;
        end
      end
      default: begin
        upd_o.ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/tst_chk.sv -----
// Port-level checker for the task slot table, bound to the top level.
module tst_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [31:0] out_task_id_o,
  input logic        last_o
);
  import tst_pkg::*;

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy low after accepted transaction");

  // A final result is never followed directly by another result.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && last_o |=> !done_o) else $error("result directly after final result");

  // Rejections and empty listings are single results without an id.
  a_single_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_REJECT || status_o == ST_EMPTY) |->
      last_o && out_task_id_o == '0) else $error("malformed reject or empty result");

  // A result that is not final is a record with a nonzero id.
  a_record_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> status_o == ST_OK && out_task_id_o != '0)
    else $error("non-final result is not a record");

endmodule

bind task_slot_table_with_budget_top tst_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .out_task_id_o (out_task_id_o),
  .last_o        (last_o)
);

// ----- dv/task_slot_table_with_budget_checker.sv -----
// Checker for the task slot table: predicts every result and compares it with the block.
`timescale 1ns / 1ps
module task_slot_table_with_budget_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  mode_i,
  input  logic [31:0] task_id_i,
  input  logic [15:0] owner_i,
  input  logic [63:0] cycle_limit_i,
  input  logic        sandboxed_i,
  input  logic [31:0] result_value_i,
  input  logic [7:0]  out_len_i,
  input  logic [63:0] amount_i,
  input  logic [2:0]  query_state_i,
  input  logic [4:0]  result_limit_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] out_task_id_i,
  input  logic [2:0]  task_state_i,
  input  logic [15:0] out_owner_i,
  input  logic [31:0] out_result_code_i,
  input  logic [63:0] out_cycles_spent_i,
  input  logic [31:0] out_mem_used_i,
  input  logic [7:0]  out_output_len_i,
  input  logic        out_sandboxed_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import tst_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] id;
    logic [2:0]  state;
    logic [15:0] owner;
    logic [31:0] code;
    logic [63:0] cpu;
    logic [31:0] mem;
    logic [7:0]  olen;
    logic        sbox;
    logic        last;
  } outcome_t;

  logic [31:0] tbl_id    [SLOTS];
  logic [2:0]  tbl_phase [SLOTS];
  logic [15:0] tbl_owner [SLOTS];
  logic [63:0] tbl_budget[SLOTS];
  logic        tbl_sbox  [SLOTS];
  logic [31:0] tbl_code  [SLOTS];
  logic [7:0]  tbl_olen  [SLOTS];
  logic [63:0] tbl_cpu   [SLOTS];
  logic [31:0] tbl_mem   [SLOTS];
  logic [31:0] next_id;
  int          used_cnt;
  outcome_t    expected_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic outcome_t short_outcome(logic [1:0] st, logic [31:0] id, logic [2:0] ph);
    outcome_t o;
    o = '0;
    o.status = st;
    o.id     = id;
    o.state  = ph;
    o.last   = 1'b1;
    return o;
  endfunction

  // Applies one accepted command to the shadow table and queues its outcomes.
  task automatic apply_command();
    int       slot;
    int       hits;
    int       limit;
    logic     ok;
    logic     hit;
    logic [64:0] sum;
    outcome_t o;
    slot = -1;
    ok   = 1'b0;
    if (mode_i == MODE_SPAWN) begin
      if (used_cnt < SLOTS) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && tbl_id[i] == '0) slot = i;
        end
      end
      if (slot < 0) begin
        expected_q.push_back(short_outcome(ST_REJECT, '0, '0));
      end else begin
        tbl_id[slot]     = next_id;
        next_id          = next_id + 1;
        tbl_phase[slot]  = PH_SPAWNED;
        tbl_owner[slot]  = owner_i;
        tbl_budget[slot] = cycle_limit_i;
        tbl_sbox[slot]   = sandboxed_i;
        tbl_code[slot]   = '0;
        tbl_olen[slot]   = '0;
        tbl_cpu[slot]    = '0;
        tbl_mem[slot]    = '0;
        used_cnt++;
        expected_q.push_back(short_outcome(ST_OK, tbl_id[slot], PH_SPAWNED));
      end
    end else if (mode_i <= MODE_MEM_REPORT) begin
      // Id zero marks a free slot, so it must never be found.
      if (task_id_i != '0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && tbl_id[i] == task_id_i) slot = i;
        end
      end
      if (slot >= 0) begin
        case (mode_i)
          MODE_START: begin
            if (tbl_phase[slot] == PH_SPAWNED) begin
              tbl_phase[slot] = PH_RUNNING;
              ok = 1'b1;
            end
          end
          MODE_COMPLETE: begin
            if (tbl_phase[slot] == PH_RUNNING) begin
              tbl_phase[slot] = PH_COMPLETED;
              tbl_code[slot]  = result_value_i;
              tbl_olen[slot]  = out_len_i;
              ok = 1'b1;
            end
          end
          MODE_CANCEL: begin
            if (tbl_phase[slot] == PH_SPAWNED || tbl_phase[slot] == PH_RUNNING) begin
              tbl_phase[slot] = PH_CANCELLED;
              ok = 1'b1;
            end
          end
          MODE_CPU_REPORT: begin
            if (tbl_phase[slot] == PH_RUNNING) begin
              sum = {1'b0, tbl_cpu[slot]} + {1'b0, amount_i};
              tbl_cpu[slot] = sum[64] ? '1 : sum[63:0];
              if (tbl_budget[slot] != '0 && tbl_cpu[slot] > tbl_budget[slot]) begin
                tbl_phase[slot] = PH_FAILED;
                tbl_code[slot]  = '1;
              end
              ok = 1'b1;
            end
          end
          default: begin
            if (tbl_phase[slot] == PH_RUNNING) begin
              sum = {33'b0, tbl_mem[slot]} + {1'b0, amount_i};
              tbl_mem[slot] = (sum > 65'h0FFFF_FFFF) ? '1 : sum[31:0];
              ok = 1'b1;
            end
          end
        endcase
      end
      if (ok) expected_q.push_back(short_outcome(ST_OK, task_id_i, tbl_phase[slot]));
      else    expected_q.push_back(short_outcome(ST_REJECT, '0, '0));
    end else begin
      limit = (result_limit_i > MAX_RES) ? MAX_RES : result_limit_i;
      hits  = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (hits < limit && tbl_id[i] != '0) begin
          if (mode_i == MODE_LIST_OWNER) hit = (tbl_owner[i] == owner_i);
          else                           hit = (tbl_phase[i] == query_state_i);
          if (hit) begin
            o        = '0;
            o.status = ST_OK;
            o.id     = tbl_id[i];
            o.state  = tbl_phase[i];
            o.owner  = tbl_owner[i];
            o.code   = tbl_code[i];
            o.cpu    = tbl_cpu[i];
            o.mem    = tbl_mem[i];
            o.olen   = tbl_olen[i];
            o.sbox   = tbl_sbox[i];
            expected_q.push_back(o);
            hits++;
          end
        end
      end
      if (hits == 0) expected_q.push_back(short_outcome(ST_EMPTY, '0, '0));
      else expected_q[$].last = 1'b1;
    end
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $realtime, name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_id[i]    = '0; tbl_phase[i] = '0; tbl_owner[i] = '0; tbl_budget[i] = '0;
        tbl_sbox[i]  = '0; tbl_code[i]  = '0; tbl_olen[i]  = '0; tbl_cpu[i]    = '0;
        tbl_mem[i]   = '0;
      end
      next_id  = 32'd1;
      used_cnt = 0;
      expected_q.delete();
      fails    = 0;
    end else begin
      // Results are checked before a new transaction is predicted at the same edge.
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, status %h id %h", $realtime, status_i,
                   out_task_id_i);
          fails++;
        end else begin
          exp_o = expected_q.pop_front();
          check_field("status", exp_o.status, status_i);
          check_field("task id", exp_o.id, out_task_id_i);
          check_field("state", exp_o.state, task_state_i);
          check_field("owner", exp_o.owner, out_owner_i);
          check_field("result code", exp_o.code, out_result_code_i);
          check_field("cycles spent", exp_o.cpu, out_cycles_spent_i);
          check_field("mem used", exp_o.mem, out_mem_used_i);
          check_field("output len", exp_o.olen, out_output_len_i);
          check_field("sandboxed", exp_o.sbox, out_sandboxed_i);
          check_field("last", exp_o.last, last_i);
        end
      end
      if (start_i && !busy_i) apply_command();
    end
  end

endmodule

// ----- dv/tb_task_slot_table_with_budget_top.sv -----
// Testbench top: drives commands into the task slot table and reports the verdict.
`timescale 1ns / 1ps
module tb_task_slot_table_with_budget_top;
  import tst_pkg::*;

  localparam int RANDOM_ITEMS = 410;
  localparam int CALM_ITEMS   = 60;  // the final random items are sent back to back
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode_i = MODE_SPAWN;
  logic [31:0] task_id_i = '0;
  logic [15:0] owner_i = '0;
  logic [63:0] ttl_i = '0;
  logic [63:0] cycle_limit_i = '0;
  logic [31:0] byte_limit_i = '0;
  logic        sandboxed_i = 1'b0;
  logic signed [31:0] result_value_i = '0;
  logic [7:0]  out_len_i = '0;
  logic [63:0] amount_i = '0;
  logic [2:0]  query_state_i = '0;
  logic [4:0]  result_limit_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] out_task_id_o;
  logic [2:0]  task_state_o;
  logic [15:0] out_owner_o;
  logic signed [31:0] out_result_code_o;
  logic [63:0] out_cycles_spent_o;
  logic [31:0] out_mem_used_o;
  logic [7:0]  out_output_len_o;
  logic        out_sandboxed_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          spawns_sent = 0;

  always #5 clk_i = ~clk_i;

  task_slot_table_with_budget_top u_dut (.*);

  task_slot_table_with_budget_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .mode_i, .task_id_i, .owner_i,
    .cycle_limit_i, .sandboxed_i, .result_value_i, .out_len_i,
    .amount_i, .query_state_i, .result_limit_i, .done_i(done_o), .status_i(status_o),
    .out_task_id_i(out_task_id_o), .task_state_i(task_state_o), .out_owner_i(out_owner_o),
    .out_result_code_i(out_result_code_o), .out_cycles_spent_i(out_cycles_spent_o),
    .out_mem_used_i(out_mem_used_o), .out_output_len_i(out_output_len_o),
    .out_sandboxed_i(out_sandboxed_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // The watchdog ends a hung run; the normal verdict comes from the stimulus process.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Picks an id: mostly one the table handed out, sometimes zero or anything at all.
  function automatic logic [31:0] pick_id();
    int issued;
    int roll;
    issued = (spawns_sent > SLOTS) ? SLOTS : spawns_sent;
    roll   = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 12 || issued == 0) return $urandom();
    return $urandom_range(1, issued);
  endfunction

  // Drives one command at the falling edge and holds it until the block takes it.
  // Start stays high afterwards, so a following command goes out back to back.
  task automatic issue(logic [2:0] mode, logic [31:0] id, logic [15:0] own,
                       logic [63:0] budget, logic [63:0] amt, logic [2:0] qstate,
                       logic [4:0] limit);
    @(negedge clk_i);
    mode_i         = mode;
    task_id_i      = id;
    owner_i        = own;
    ttl_i          = rand64();
    cycle_limit_i  = budget;
    byte_limit_i   = $urandom();
    sandboxed_i    = $urandom_range(0, 1);
    result_value_i = $urandom();
    out_len_i      = $urandom_range(0, 255);
    amount_i       = amt;
    query_state_i  = qstate;
    result_limit_i = limit;
    start          = 1'b1;
    do @(posedge clk_i); while (busy);
    if (mode == MODE_SPAWN) spawns_sent++;
  endtask

  task automatic idle_burst();
    int gap;
    gap = $urandom_range(1, 9);
    @(negedge clk_i);
    start = 1'b0;
    repeat (gap - 1) @(negedge clk_i);
  endtask

  initial begin
    int          roll;
    logic [2:0]  mode;
    logic [63:0] budget;
    logic [63:0] amt;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty listings, field extremes, budget failure and saturation.
    issue(MODE_LIST_STATE, '0, '0, '0, '0, PH_SPAWNED, 5'd16);
    issue(MODE_START, '0, '0, '0, '0, '0, '0);             // id zero is rejected
    issue(MODE_SPAWN, '0, 16'hFFFF, 64'd100, '0, '0, '0);  // id 1, small budget
    issue(MODE_SPAWN, '0, 16'h0000, '0, '0, '0, '0);       // id 2, unlimited
    issue(MODE_SPAWN, '0, 16'hFFFF, '1, '0, '0, '0);       // id 3, largest budget
    issue(MODE_START, 32'd1, '0, '0, '0, '0, '0);
    issue(MODE_START, 32'd1, '0, '0, '0, '0, '0);          // illegal transition
    issue(MODE_CPU_REPORT, 32'd1, '0, '0, 64'd100, '0, '0); // exactly at budget
    issue(MODE_CPU_REPORT, 32'd1, '0, '0, 64'd1, '0, '0);   // over budget: fails
    issue(MODE_START, 32'd2, '0, '0, '0, '0, '0);
    issue(MODE_CPU_REPORT, 32'd2, '0, '0, '1, '0, '0);
    issue(MODE_CPU_REPORT, 32'd2, '0, '0, '1, '0, '0);      // cpu usage saturates
    issue(MODE_MEM_REPORT, 32'd2, '0, '0, 64'hFFFF_FFFE, '0, '0);
    issue(MODE_MEM_REPORT, 32'd2, '0, '0, 64'd5, '0, '0);   // memory saturates
    issue(MODE_MEM_REPORT, 32'd2, '0, '0, '1, '0, '0);
    issue(MODE_COMPLETE, 32'd2, '0, '0, '0, '0, '0);
    issue(MODE_CANCEL, 32'd3, '0, '0, '0, '0, '0);
    issue(MODE_CANCEL, 32'd3, '0, '0, '0, '0, '0);          // already cancelled
    issue(MODE_COMPLETE, 32'hFFFF_FFFF, '0, '0, '0, '0, '0); // unknown id
    issue(MODE_LIST_OWNER, '0, 16'hFFFF, '0, '0, '0, 5'd31); // limit clamps to 16
    issue(MODE_LIST_OWNER, '0, 16'hFFFF, '0, '0, '0, 5'd1);
    issue(MODE_LIST_OWNER, '0, 16'hFFFF, '0, '0, '0, 5'd0);  // zero limit finds nothing
    issue(MODE_LIST_STATE, '0, '0, '0, '0, 3'd7, 5'd16);     // state code above range
    issue(MODE_LIST_STATE, '0, '0, '0, '0, 3'd4, 5'd16);     // expired never occurs
    idle_burst();

    // Random part: lifecycle commands on real ids dominate, with noise mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (spawns_sent < 20 && roll < 40) mode = MODE_SPAWN;
      else if (roll < 6)  mode = MODE_SPAWN;
      else if (roll < 22) mode = MODE_START;
      else if (roll < 34) mode = MODE_COMPLETE;
      else if (roll < 42) mode = MODE_CANCEL;
      else if (roll < 62) mode = MODE_CPU_REPORT;
      else if (roll < 74) mode = MODE_MEM_REPORT;
      else if (roll < 87) mode = MODE_LIST_OWNER;
      else                mode = MODE_LIST_STATE;
      case ($urandom_range(0, 3))
        0:       budget = '0;
        1:       budget = rand64();
        default: budget = $urandom_range(1, 600);
      endcase
      amt = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 300));
      issue(mode, pick_id(), 16'($urandom_range(0, 3)) ^ (($urandom_range(0, 7) == 0) ?
            16'($urandom()) : 16'h0), budget, amt, 3'($urandom_range(0, 7)),
            5'($urandom_range(0, 31)));
      if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0) idle_burst();
    end

    @(negedge clk_i);
    start = 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/tst_pkg.sv
src/tst_mem.sv
src/tst_upd.sv
src/task_slot_table_with_budget_top.sv
src/tst_chk.sv
dv/task_slot_table_with_budget_checker.sv
dv/tb_task_slot_table_with_budget_top.sv
